[rtl/core/msu_pkg.sv]
// Package for the midtones transfer stretch unit.
// Holds sample width default, register indexes and mode codes; no dependencies.
package msu_pkg;

   localparam int SampleBitsDefault = 16;
   localparam int CsrIndexBits      = 3;
   localparam int EnableBits        = 3;
   localparam int ModeBits          = 2;
   localparam int LaneCount         = 3;

   localparam logic [CsrIndexBits-1:0] CSR_SHADOWS    = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_MIDTONES   = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_HIGHLIGHTS = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_ENABLE     = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_MODE       = 3'd4;

   typedef enum logic [ModeBits-1:0] {
      MODE_MONO     = 2'd0,
      MODE_RGB      = 2'd1,
      MODE_PASS     = 2'd2,
      MODE_PASS_ALT = 2'd3
   } mode_type;

endpackage

[rtl/core/msu_if.sv]
// Word channels of the stretch unit: pixel request and pixel response.
// Depends on nothing; widths follow the SB parameter.
interface msu_req_if #(parameter int SB = 16);
   logic          valid;
   logic          ready;
   logic [SB-1:0] sample_r;
   logic [SB-1:0] sample_g;
   logic [SB-1:0] sample_b;
   modport source (output valid, sample_r, sample_g, sample_b, input ready);
   modport sink   (input valid, sample_r, sample_g, sample_b, output ready);
endinterface

interface msu_rsp_if #(parameter int SB = 16);
   logic          valid;
   logic          ready;
   logic [SB-1:0] out_r;
   logic [SB-1:0] out_g;
   logic [SB-1:0] out_b;
   modport source (output valid, out_r, out_g, out_b, input ready);
   modport sink   (input valid, out_r, out_g, out_b, output ready);
endinterface

[rtl/core/msu_lane.sv]
// One sample lane: clip tests, two products, then a one-bit-per-stage divider
// with rounding and saturation. Uses msu_pkg; stage enables come from the top.
module msu_lane #(
   parameter int SB = 16
) (
   input  logic           clock,
   input  logic [SB+4:0]  en,
   input  logic [SB-1:0]  x,
   input  logic           stretch,
   input  logic [SB-1:0]  lo,
   input  logic [SB-1:0]  hi,
   input  logic [SB-1:0]  m,
   output logic [SB-1:0]  val,
   output logic [SB-1:0]  raw,
   output logic           sel
);
   import msu_pkg::*;

   localparam int N  = SB + 5;
   localparam int CW = SB + 3;
   localparam int DW = 2 * SB + 1;
   localparam int RW = 2 * SB + 2;
   localparam int QW = SB + 1;
   localparam logic [SB-1:0] FS = {SB{1'b1}};

   // Control bundle: {raw sample, stretch, at-or-below lo, at-or-above hi}.
   logic [CW-1:0] ctl_ff [N];

   logic [SB-1:0]   u_ff, dmu_ff, fm_ff, m_ff;
   logic [2*SB-1:0] num1_ff, mt1_ff;
   logic [DW-1:0]   rem_ff [SB+1];
   logic [QW-1:0]   q_ff   [SB+1];
   logic [DW-1:0]   num_ff [SB+1];
   logic [DW-1:0]   den_ff [SB+1];
   logic [DW-1:0]   crem_ff, cden_ff;
   logic [QW:0]     cq_ff;
   logic [SB-1:0]   val_ff;

   logic [RW-1:0]   c_sum;
   logic [QW:0]     q_rnd;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ctl_ff[0] <= {x, stretch, x <= lo, x >= hi};
         u_ff      <= x - lo;
         dmu_ff    <= hi - x;
         fm_ff     <= FS - m;
         m_ff      <= m;
      end
      if (en[1]) begin
         num1_ff <= fm_ff * u_ff;
         mt1_ff  <= m_ff * dmu_ff;
      end
      if (en[2]) begin
         den_ff[0] <= {1'b0, num1_ff} + {1'b0, mt1_ff};
         num_ff[0] <= {1'b0, num1_ff};
         rem_ff[0] <= {1'b0, num1_ff};
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k < N; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (en[k]) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 1; j <= SB; j++) begin : g_div
      logic [RW-1:0] shifted;
      logic          take;
      assign shifted = {rem_ff[j-1], 1'b0};
      assign take    = shifted >= {1'b0, den_ff[j-1]};
      always_ff @(posedge clock) begin
         if (en[2+j]) begin
            rem_ff[j] <= take ? DW'(shifted - {1'b0, den_ff[j-1]}) : DW'(shifted);
            q_ff[j]   <= {q_ff[j-1][QW-2:0], take};
            num_ff[j] <= num_ff[j-1];
            den_ff[j] <= den_ff[j-1];
         end
      end
   end

   // The divider gives num*2^SB; full scale is 2^SB-1, so take num back out.
   assign c_sum = {1'b0, rem_ff[SB]} + {1'b0, den_ff[SB]} - {1'b0, num_ff[SB]};
   assign q_rnd = ({crem_ff, 1'b0} >= {1'b0, cden_ff}) ? cq_ff + 1'b1 : cq_ff;

   always_ff @(posedge clock) begin
      if (en[SB+3]) begin
         cden_ff <= den_ff[SB];
         if (rem_ff[SB] >= num_ff[SB]) begin
            crem_ff <= rem_ff[SB] - num_ff[SB];
            cq_ff   <= {1'b0, q_ff[SB]};
         end else begin
            crem_ff <= DW'(c_sum);
            cq_ff   <= {1'b0, q_ff[SB]} - 1'b1;
         end
      end
      if (en[SB+4]) begin
         if (ctl_ff[SB+3][1])
            val_ff <= '0;
         else if (ctl_ff[SB+3][0])
            val_ff <= FS;
         else if (q_rnd > {2'b00, FS})
            val_ff <= FS;
         else
            val_ff <= q_rnd[SB-1:0];
      end
   end

   assign val = val_ff;
   assign raw = ctl_ff[N-1][CW-1:3];
   assign sel = ctl_ff[N-1][2];

endmodule

[rtl/core/msu_merge.sv]
// Output stage: picks stretched or raw sample per lane and registers the word.
// Uses msu_pkg for the lane count.
module msu_merge #(
   parameter int SB = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [msu_pkg::LaneCount-1:0][SB-1:0] val,
   input  logic [msu_pkg::LaneCount-1:0][SB-1:0] raw,
   input  logic [msu_pkg::LaneCount-1:0]         sel,
   output logic [msu_pkg::LaneCount-1:0][SB-1:0] pix
);
   import msu_pkg::*;

   logic [LaneCount-1:0][SB-1:0] pix_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < LaneCount; c++)
            pix_ff[c] <= sel[c] ? val[c] : raw[c];
      end
   end

   assign pix = pix_ff;

endmodule

[rtl/core/mtf_pixel_stretch_unit.sv]
// Top level of the midtones transfer stretch unit.
// Uses msu_pkg, msu_req_if/msu_rsp_if, msu_lane and msu_merge.
//
// The unit takes one pixel word per clock and returns one stretched pixel word
// per clock while the response side is ready: three lanes run in
// parallel, each a fully pipelined datapath of clip tests, two products and a
// restoring divider that resolves one quotient bit per stage, followed by a
// correction and a rounding stage; a merge register forms the response word.
// Every stage holds independently, so bubbles close up under backpressure and
// a new word is taken while a finished word waits at the output, as long as a
// stage is empty. The csr port may be written only while the unit is empty.
module mtf_pixel_stretch_unit #(
   parameter int SAMPLE_BITS = msu_pkg::SampleBitsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   msu_req_if.sink                          req_if,
   msu_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [msu_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]           csr_wdata
);
   import msu_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int N  = SB + 5;   // lane stages; the merge register is stage N

   logic [SB-1:0]         lo_ff, m_ff, hi_ff;
   logic [EnableBits-1:0] enable_ff;
   mode_type              mode_ff;

   // Configuration registers, reset to an identity-like midpoint stretch.
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff     <= '0;
         m_ff      <= {1'b1, {(SB-1){1'b0}}};
         hi_ff     <= '1;
         enable_ff <= '1;
         mode_ff   <= MODE_RGB;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHADOWS:    lo_ff     <= csr_wdata;
            CSR_MIDTONES:   m_ff      <= csr_wdata;
            CSR_HIGHLIGHTS: hi_ff     <= csr_wdata;
            CSR_ENABLE:     enable_ff <= csr_wdata[EnableBits-1:0];
            CSR_MODE:       mode_ff   <= mode_type'(csr_wdata[ModeBits-1:0]);
            default: ;
         endcase
      end
   end

   // Which lanes stretch: mono stretches only the first sample, RGB follows
   // the enable bits, and the remaining codes pass everything through.
   logic [LaneCount-1:0] stretch;
   always_comb begin
      unique case (mode_ff)
         MODE_MONO: stretch = 3'b001;
         MODE_RGB:  stretch = enable_ff;
         default:   stretch = '0;
      endcase
   end

   // Valid bit per stage; a stage advances when it is empty or its successor
   // advances, which lets bubbles collapse behind a stalled output.
   logic [N:0] v_ff, v_in, adv;
   always_comb begin
      adv[N] = !v_ff[N] || rsp_if.ready;
      for (int k = N - 1; k >= 0; k--)
         adv[k] = !v_ff[k] || adv[k+1];
      v_in[0] = adv[0] ? req_if.valid : v_ff[0];
      for (int k = 1; k <= N; k++)
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   assign req_if.ready = adv[0];

   logic [LaneCount-1:0][SB-1:0] samp, val, raw, pix;
   logic [LaneCount-1:0]         sel;

   assign samp[0] = req_if.sample_r;
   assign samp[1] = req_if.sample_g;
   assign samp[2] = req_if.sample_b;

   for (genvar c = 0; c < LaneCount; c++) begin : g_lane
      msu_lane #(.SB(SB)) u_lane (
         .clock   (clock),
         .en      (adv[N-1:0]),
         .x       (samp[c]),
         .stretch (stretch[c]),
         .lo      (lo_ff),
         .hi      (hi_ff),
         .m       (m_ff),
         .val     (val[c]),
         .raw     (raw[c]),
         .sel     (sel[c])
      );
   end

   msu_merge #(.SB(SB)) u_merge (
      .clock (clock),
      .en    (adv[N]),
      .val   (val),
      .raw   (raw),
      .sel   (sel),
      .pix   (pix)
   );

   assign rsp_if.valid = v_ff[N];
   assign rsp_if.out_r = pix[0];
   assign rsp_if.out_g = pix[1];
   assign rsp_if.out_b = pix[2];

`ifndef NO_ASSERTIONS
   // An accepted word always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v_ff[0])
      else $error("accepted word did not enter the lane pipeline");

   // A response only appears when the last lane stage held a word.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(v_ff[N-1]))
      else $error("response word appeared without a word in the last stage");

   // A full last lane stage that cannot advance keeps its word.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[N-1] && !adv[N]) |=> v_ff[N-1])
      else $error("stalled word was lost in the last lane stage");
`endif

endmodule
